@@ rtl/core/sha256_single_block_compress_assert.svh @@
// Assertion macros for the SHA-256 single-block compressor.
`ifndef SHA256_SINGLE_BLOCK_COMPRESS_ASSERT_SVH
`define SHA256_SINGLE_BLOCK_COMPRESS_ASSERT_SVH
`ifndef ASSERT_OFF
`define SBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SBC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SBC_ASSERT(label, prop, msg)
`define SBC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ rtl/core/sha256sbc_pkg.sv @@
// Shared types, constants and SHA-256 functions for the block compressor.
package sha256sbc_pkg;

    localparam int BLOCK_WORDS  = 16;
    localparam int DIGEST_WORDS = 8;
    localparam int ROUNDS       = 64;
    localparam int WORD_W       = 32;
    localparam int WCNT_W       = $clog2(BLOCK_WORDS);
    localparam int RND_W        = $clog2(ROUNDS);
    localparam int DIDX_W       = $clog2(DIGEST_WORDS);

    localparam logic [WCNT_W-1:0] LAST_WORD   = WCNT_W'(BLOCK_WORDS - 1);
    localparam logic [RND_W-1:0]  LAST_ROUND  = RND_W'(ROUNDS - 1);
    localparam logic [DIDX_W-1:0] LAST_DIGEST = DIDX_W'(DIGEST_WORDS - 1);

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;   // shift in a message word
        logic step;   // shift in the next expanded schedule word
    } t_sched_ctl;

    typedef struct packed {
        logic init;   // load initial hash values
        logic step;   // run one round
    } t_round_ctl;

    localparam t_word ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word INIT_H [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

@@ rtl/core/sha256sbc_sched.sv @@
// Message schedule: 16-word shift window with in-place expansion.
module sha256sbc_sched (
    input  logic                      i_clk,
    input  sha256sbc_pkg::t_sched_ctl i_ctl,
    input  sha256sbc_pkg::t_word      i_word,
    output sha256sbc_pkg::t_word      o_wt
);

    // r_win[0] holds W[t] for the current round
    sha256sbc_pkg::t_word r_win [sha256sbc_pkg::BLOCK_WORDS];
    sha256sbc_pkg::t_word n_new;

    always_comb begin
        // W[t+16] from the window taps
        n_new = sha256sbc_pkg::small_sigma1(r_win[14]) + r_win[9]
              + sha256sbc_pkg::small_sigma0(r_win[1]) + r_win[0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load || i_ctl.step) begin
            for (int i = 0; i < sha256sbc_pkg::BLOCK_WORDS - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[sha256sbc_pkg::BLOCK_WORDS-1] <= i_ctl.load ? i_word : n_new;
        end
    end

    assign o_wt = r_win[0];

endmodule

@@ rtl/core/sha256sbc_round.sv @@
// Round unit: working variables a..h, one SHA-256 round per step, digest add.
module sha256sbc_round (
    input  logic                                   i_clk,
    input  sha256sbc_pkg::t_round_ctl              i_ctl,
    input  sha256sbc_pkg::t_word                   i_wt,
    input  sha256sbc_pkg::t_word                   i_k,
    input  logic [sha256sbc_pkg::DIDX_W-1:0]       i_out_idx,
    output sha256sbc_pkg::t_word                   o_digest
);

    sha256sbc_pkg::t_word r_var [sha256sbc_pkg::DIGEST_WORDS];
    sha256sbc_pkg::t_word n_t1;
    sha256sbc_pkg::t_word n_t2;
    sha256sbc_pkg::t_word n_ch;
    sha256sbc_pkg::t_word n_maj;

    always_comb begin
        n_ch  = (r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]);
        n_maj = (r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]);
        n_t1  = r_var[7] + sha256sbc_pkg::big_sigma1(r_var[4]) + n_ch + i_k + i_wt;
        n_t2  = sha256sbc_pkg::big_sigma0(r_var[0]) + n_maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            for (int i = 0; i < sha256sbc_pkg::DIGEST_WORDS; i++) begin
                r_var[i] <= sha256sbc_pkg::INIT_H[i];
            end
        end else if (i_ctl.step) begin
            r_var[0] <= n_t1 + n_t2;
            r_var[1] <= r_var[0];
            r_var[2] <= r_var[1];
            r_var[3] <= r_var[2];
            r_var[4] <= r_var[3] + n_t1;
            r_var[5] <= r_var[4];
            r_var[6] <= r_var[5];
            r_var[7] <= r_var[6];
        end
    end

    // feed-forward of the initial hash, one word at a time on the way out
    assign o_digest = r_var[i_out_idx] + sha256sbc_pkg::INIT_H[i_out_idx];

endmodule

@@ rtl/core/sha256_single_block_compress.sv @@
// SHA-256 single-block compressor: top level with the round sequencer.
//
// Input channel (i_msg_valid / o_msg_ready / i_message_word): sixteen
// big-endian 32-bit words make one 512-bit block. Every block is hashed
// on its own from the standard initial hash values; no padding, no chaining.
// Output channel (o_dig_valid / i_dig_ready / o_digest_word / o_last_word):
// eight digest words per block, word zero first, o_last_word high on the
// eighth.
// Timing: words one to fifteen only load the schedule window. After the
// sixteenth transaction the shared round unit runs 64 rounds, one per
// cycle, then the digest is offered from the next cycle. No word is taken
// while the rounds run, but words of the next block are taken while the
// digest drains (all but its sixteenth), so back-to-back blocks overlap
// loading with draining, and the round loop sets their pace.
// A stalled receiver holds the current digest word; input keeps loading up
// to the fifteenth word, then o_msg_ready stays low until the digest drains.
// Reset (synchronous, active low) returns the sequencer to loading with no
// words held and no digest pending.
module sha256_single_block_compress (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_msg_valid,
    output logic                 o_msg_ready,
    input  logic [31:0]          i_message_word,
    output logic                 o_dig_valid,
    input  logic                 i_dig_ready,
    output logic [31:0]          o_digest_word,
    output logic                 o_last_word
);

    sha256sbc_pkg::t_state                 r_state;
    sha256sbc_pkg::t_state                 n_state;
    logic [sha256sbc_pkg::WCNT_W-1:0]      r_word_cnt;
    logic [sha256sbc_pkg::RND_W-1:0]       r_round;
    logic [sha256sbc_pkg::DIDX_W-1:0]      r_out_idx;
    logic                                  in_acc;
    logic                                  out_acc;
    logic                                  blk_done;
    sha256sbc_pkg::t_sched_ctl             sched_ctl;
    sha256sbc_pkg::t_round_ctl             round_ctl;
    sha256sbc_pkg::t_word                  wt;

    assign in_acc   = i_msg_valid && o_msg_ready;
    assign out_acc  = o_dig_valid && i_dig_ready;
    assign blk_done = in_acc && (r_word_cnt == sha256sbc_pkg::LAST_WORD);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sha256sbc_pkg::ST_LOAD: begin
                if (blk_done) n_state = sha256sbc_pkg::ST_ROUND;
            end
            sha256sbc_pkg::ST_ROUND: begin
                if (r_round == sha256sbc_pkg::LAST_ROUND) n_state = sha256sbc_pkg::ST_OUT;
            end
            sha256sbc_pkg::ST_OUT: begin
                if (out_acc && (r_out_idx == sha256sbc_pkg::LAST_DIGEST)) begin
                    n_state = sha256sbc_pkg::ST_LOAD;
                end
            end
            default: n_state = sha256sbc_pkg::ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_msg_ready    = 1'b0;
        o_dig_valid    = 1'b0;
        round_ctl.step = 1'b0;
        case (r_state)
            sha256sbc_pkg::ST_LOAD: begin
                o_msg_ready = 1'b1;
            end
            sha256sbc_pkg::ST_ROUND: begin
                round_ctl.step = 1'b1;
            end
            sha256sbc_pkg::ST_OUT: begin
                o_dig_valid = 1'b1;
                // working vars are still busy: hold off the block's last word
                o_msg_ready = (r_word_cnt != sha256sbc_pkg::LAST_WORD);
            end
            default: begin
                o_msg_ready = 1'b0;
            end
        endcase
        sched_ctl.load = in_acc;
        sched_ctl.step = round_ctl.step;
        round_ctl.init = blk_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sha256sbc_pkg::ST_LOAD;
            r_word_cnt <= '0;
            r_round    <= '0;
            r_out_idx  <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) r_word_cnt <= r_word_cnt + 1'b1;
            if (round_ctl.step) r_round <= r_round + 1'b1;
            if (out_acc) r_out_idx <= r_out_idx + 1'b1;
        end
    end

    sha256sbc_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (sched_ctl),
        .i_word (i_message_word),
        .o_wt   (wt)
    );

    sha256sbc_round u_round (
        .i_clk     (i_clk),
        .i_ctl     (round_ctl),
        .i_wt      (wt),
        .i_k       (sha256sbc_pkg::ROUND_K[r_round]),
        .i_out_idx (r_out_idx),
        .o_digest  (o_digest_word)
    );

    assign o_last_word = (r_out_idx == sha256sbc_pkg::LAST_DIGEST);

`include "sha256_single_block_compress_assert.svh"

    `SBC_ASSERT(a_round_idle_zero, (r_state != sha256sbc_pkg::ST_ROUND) |-> (r_round == '0), "round counter not zero outside rounds")
    `SBC_ASSERT(a_block_starts, blk_done |=> (r_state == sha256sbc_pkg::ST_ROUND), "sixteenth word did not start rounds")
    `SBC_ASSERT(a_rounds_to_out, ((r_state == sha256sbc_pkg::ST_ROUND) && (r_round == sha256sbc_pkg::LAST_ROUND)) |=> (o_dig_valid && (r_out_idx == '0)), "digest not offered from word zero after last round")
    `SBC_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (!o_dig_valid && (r_word_cnt == '0)), "reset did not clear sequencer")

endmodule

@@ bench/tb_sha256_single_block_compress.sv @@
// Self-checking testbench for the SHA-256 single-block compressor.
`timescale 1ns / 100ps

module tb_sha256_single_block_compress;

    localparam int CLK_HALF    = 6;
    localparam int RESET_CYC   = 7;
    localparam int CYCLE_LIMIT = 250000;
    localparam int HOLD_OFF    = 400;

    localparam bit [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam bit [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct {
        bit [31:0] word;
        bit        last;
    } t_digest_exp;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_msg_valid    = 1'b0;
    logic [31:0] i_message_word = '0;
    logic        i_dig_ready    = 1'b0;
    logic        o_msg_ready;
    logic        o_dig_valid;
    logic [31:0] o_digest_word;
    logic        o_last_word;

    t_digest_exp digest_expect_q [$];
    bit [31:0]   msg_block [16];
    int          words_loaded = 0;
    int          error_count  = 0;
    int unsigned cycle_count  = 0;

    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    bit hold_off_toggle = 1'b0;

    sha256_single_block_compress dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_msg_valid    (i_msg_valid),
        .o_msg_ready    (o_msg_ready),
        .i_message_word (i_message_word),
        .o_dig_valid    (o_dig_valid),
        .i_dig_ready    (i_dig_ready),
        .o_digest_word  (o_digest_word),
        .o_last_word    (o_last_word)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic bit [31:0] ror32(input bit [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Full schedule expansion and 64 rounds over the buffered block.
    function automatic void predict_digest();
        bit [31:0] w [64];
        bit [31:0] v [8];
        bit [31:0] t1;
        bit [31:0] t2;
        bit [31:0] sg0;
        bit [31:0] sg1;
        t_digest_exp exp_item;
        for (int t = 0; t < 16; t++) w[t] = msg_block[t];
        for (int t = 16; t < 64; t++) begin
            sg0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
            sg1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + sg0 + w[t-7] + sg1;
        end
        for (int i = 0; i < 8; i++) v[i] = SHA_IV[i];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) begin
            exp_item.word = v[i] + SHA_IV[i];
            exp_item.last = (i == 7);
            digest_expect_q.push_back(exp_item);
        end
    endfunction

    function automatic void absorb_message_word(input bit [31:0] w);
        msg_block[words_loaded] = w;
        words_loaded++;
        if (words_loaded == 16) begin
            predict_digest();
            words_loaded = 0;
        end
    endfunction

    function automatic int pick_gap(input bit enable);
        int r;
        r = $urandom_range(0, 99);
        if (!enable || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic bit [31:0] random_word();
        case ($urandom_range(0, 15))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Drives one word and returns on the edge where the transaction happens.
    task automatic send_message_word(input bit [31:0] w, input int gap);
        if (gap > 0) begin
            i_msg_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_msg_valid    <= 1'b1;
        i_message_word <= w;
        do @(posedge i_clk); while (!o_msg_ready);
        absorb_message_word(w);
    endtask

    task automatic send_random_block();
        for (int i = 0; i < 16; i++) send_message_word(random_word(), pick_gap(tx_idle_on));
    endtask

    // Stop offering words, then wait for every expected digest word.
    task automatic wait_drained();
        i_msg_valid <= 1'b0;
        while (digest_expect_q.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random runs of ready and stall, plus a long hold-off on request.
    initial begin
        int  run_left;
        int  hold_left;
        bit  seen_toggle;
        run_left    = 0;
        hold_left   = 0;
        seen_toggle = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_toggle != seen_toggle) begin
                seen_toggle = hold_off_toggle;
                hold_left   = HOLD_OFF;
            end
            if (hold_left > 0) begin
                i_dig_ready <= 1'b0;
                hold_left--;
                run_left = 0;
            end else if (!rx_idle_on) begin
                i_dig_ready <= 1'b1;
            end else if (run_left > 0) begin
                run_left--;
            end else if (!i_dig_ready) begin
                i_dig_ready <= 1'b1;
                run_left = $urandom_range(0, 8);
            end else begin
                i_dig_ready <= 1'b0;
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30)
                                                       : $urandom_range(0, 2);
            end
        end
    end

    // Digest checker
    always @(posedge i_clk) begin
        t_digest_exp exp_item;
        if (i_rst_n && o_dig_valid && i_dig_ready) begin
            if (digest_expect_q.size() == 0) begin
                $display("%0t: unexpected digest transaction: word %h last %b",
                         $time, o_digest_word, o_last_word);
                error_count++;
            end else begin
                exp_item = digest_expect_q.pop_front();
                if (o_digest_word !== exp_item.word) begin
                    $display("%0t: digest_word mismatch: expected %h, got %h",
                             $time, exp_item.word, o_digest_word);
                    error_count++;
                end
                if (o_last_word !== exp_item.last) begin
                    $display("%0t: last_word mismatch: expected %b, got %b",
                             $time, exp_item.last, o_last_word);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("sha256_single_block_compress test failed");
        $finish;
    end

    // Corner words: all zeros, all ones, single bits, alternating patterns.
    task automatic test_extreme_words();
        bit [31:0] words [16] = '{
            32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
            32'h7fff_ffff, 32'hffff_fffe, 32'haaaa_aaaa, 32'h5555_5555,
            32'h6162_6380, 32'h0000_0000, 32'hffff_ffff, 32'h0f0f_0f0f,
            32'hf0f0_f0f0, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0018
        };
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int i = 0; i < 16; i++) send_message_word(words[i], pick_gap(tx_idle_on));
        wait_drained();
    endtask

    task automatic test_random_blocks(input int n_blocks);
        for (int b = 0; b < n_blocks; b++) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            send_random_block();
        end
        wait_drained();
    endtask

    // Full rate on both sides: next block loads while the digest drains.
    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (3) send_random_block();
        wait_drained();
    endtask

    // Receiver stalls long enough that the input side fills and blocks.
    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_off_toggle <= ~hold_off_toggle;
        repeat (2) send_random_block();
        wait_drained();
    endtask

    initial begin
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extreme_words();
        test_random_blocks(11);
        test_back_to_back();
        test_output_backpressure();

        wait_drained();
        repeat (80) @(posedge i_clk);

        if (error_count == 0) begin
            $display("sha256_single_block_compress test passed");
        end else begin
            $display("sha256_single_block_compress test failed");
        end
        $finish;
    end

endmodule
